// ===== hdl/text_console_writer_assert.svh =====
// Assertion macros for the text console writer.
// Included by the modules that check their own logic; expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Check a property on every rising edge outside reset
`define TCW_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed in the next cycle by another
`define TCW_CHECK_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// Shared types, codes and helper functions for the text console writer.
// No dependencies; the stage modules and the top level import this package.
package tcw_pkg;

    // Offset width and derived types
    localparam int POS_BITS = 16;
    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic signed [POS_BITS:0] diff_t;

    // Screen geometry
    localparam int   CELL_BYTES   = 2;
    localparam int   TAB_CELLS    = 4;
    localparam pos_t ROW_BYTES    = POS_BITS'(160);
    localparam pos_t STEP_BYTES   = POS_BITS'(CELL_BYTES);
    localparam pos_t TAB_BYTES    = POS_BITS'(CELL_BYTES * TAB_CELLS);
    localparam diff_t SCROLL_LIMIT = diff_t'(4000);

    // Row division: x / 160 = (x >> 5) / 5, the /5 done by reciprocal multiply
    localparam int HI_BITS   = POS_BITS - 5;
    localparam int PROD_BITS = HI_BITS + 15;
    localparam logic [14:0] DIV5_RECIP = 15'd13108;
    localparam int DIV5_SHIFT = 16;

    // CRT byte extraction
    localparam int CRT_HI_SHIFT = 9;
    localparam int CRT_LO_SHIFT = 1;

    // Command codes
    localparam logic [2:0] CMD_PUT         = 3'd0;
    localparam logic [2:0] CMD_SCROLL_UP   = 3'd1;
    localparam logic [2:0] CMD_SCROLL_DOWN = 3'd2;
    localparam logic [2:0] CMD_LEFT        = 3'd3;
    localparam logic [2:0] CMD_RIGHT       = 3'd4;

    // Special characters
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    // Result kinds
    localparam logic [1:0] KIND_CELL   = 2'd0;
    localparam logic [1:0] KIND_CRT    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // CRT register codes
    localparam logic [1:0] CRT_CURSOR_HI = 2'd0;
    localparam logic [1:0] CRT_CURSOR_LO = 2'd1;
    localparam logic [1:0] CRT_START_HI  = 2'd2;
    localparam logic [1:0] CRT_START_LO  = 2'd3;

    // Operation classes passed from the command stage to the scroll stage
    localparam logic [1:0] OP_MOVE        = 2'd0;
    localparam logic [1:0] OP_SCROLL_UP   = 2'd1;
    localparam logic [1:0] OP_SCROLL_DOWN = 2'd2;
    localparam logic [1:0] OP_STATUS      = 2'd3;

    localparam logic [7:0] ATTR_RESET = 8'd7;

    // Decoded command, cursor already moved
    typedef struct packed {
        logic [1:0] op;
        logic       err;
        logic [2:0] n_cells;
        logic [7:0] cell_char;
        pos_t       cell_base;
        pos_t       cursor;
    } cmd_rec_t;

    // Everything needed to list the results of one transaction
    typedef struct packed {
        logic       status_en;
        logic       err;
        logic       cursor_en;
        logic       start_en;
        logic [2:0] n_cells;
        logic [7:0] cell_char;
        pos_t       cell_base;
        pos_t       cursor;
        pos_t       start;
        logic [3:0] count;
    } plan_t;

    // Start of the row holding a byte offset
    function automatic pos_t row_base(input pos_t pos);
        logic [HI_BITS-1:0]   hi;
        logic [PROD_BITS-1:0] prod;
        pos_t                 q;
        hi   = pos[POS_BITS-1:5];
        prod = PROD_BITS'(hi) * PROD_BITS'(DIV5_RECIP);
        q    = POS_BITS'(prod >> DIV5_SHIFT);
        return (q << 7) + (q << 5);
    endfunction

    // Byte written to a CRT high or low register
    function automatic logic [7:0] crt_byte(input pos_t value, input logic high);
        return high ? 8'(value >> CRT_HI_SHIFT) : 8'(value >> CRT_LO_SHIFT);
    endfunction

endpackage

// ===== hdl/tcw_cmd_if.sv =====
// Command channel of the text console writer: valid/ready plus command payload.
// No dependencies.
interface tcw_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] char_code;

    modport source (output valid, output command, output char_code, input ready);
    modport sink   (input valid, input command, input char_code, output ready);
endinterface

// ===== hdl/tcw_res_if.sv =====
// Result channel of the text console writer: valid/ready plus one result item.
// No dependencies.
interface tcw_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] cell_offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;
    logic [1:0]  crt_register;
    logic [7:0]  crt_value;
    logic        error;
    logic        last;

    modport source (output valid, output kind, output cell_offset, output cell_char,
                    output cell_attribute, output crt_register, output crt_value,
                    output error, output last, input ready);
    modport sink   (input valid, input kind, input cell_offset, input cell_char,
                    input cell_attribute, input crt_register, input crt_value,
                    input error, input last, output ready);
endinterface

// ===== hdl/tcw_cmd_stage.sv =====
// Command stage: input register, command decode and cursor offset register.
// Depends on tcw_pkg and tcw_cmd_if.
module tcw_cmd_stage
    import tcw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tcw_cmd_if.sink   cmd,
    output logic      rec_valid,
    input  logic      rec_ready,
    output cmd_rec_t  rec
);

    logic       in_valid_reg;
    logic [2:0] in_command_reg;
    logic [7:0] in_char_reg;
    pos_t       cursor_reg;
    logic       rec_valid_reg;
    cmd_rec_t   rec_reg;
    cmd_rec_t   rec_next;
    logic       advance;
    logic       back_blocked;

    // Move on when the decoded record slot is free or draining
    assign advance   = in_valid_reg && (!rec_valid_reg || rec_ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    assign back_blocked = (cursor_reg < STEP_BYTES);

    // Decode the command and work out the new cursor
    always_comb
    begin
        rec_next           = '0;
        rec_next.op        = OP_STATUS;
        rec_next.cell_base = cursor_reg;
        rec_next.cursor    = cursor_reg;
        case (in_command_reg)
            CMD_PUT:
            begin
                case (in_char_reg)
                    CH_NEWLINE:
                    begin
                        rec_next.op     = OP_MOVE;
                        rec_next.cursor = row_base(cursor_reg) + ROW_BYTES;
                    end
                    CH_TAB:
                    begin
                        rec_next.op        = OP_MOVE;
                        rec_next.n_cells   = 3'(TAB_CELLS);
                        rec_next.cell_char = CH_BLANK;
                        rec_next.cursor    = cursor_reg + TAB_BYTES;
                    end
                    CH_BACKSPACE:
                    begin
                        if (back_blocked)
                        begin
                            rec_next.err = 1'b1;
                        end
                        else
                        begin
                            rec_next.op     = OP_MOVE;
                            rec_next.cursor = cursor_reg - STEP_BYTES;
                        end
                    end
                    default:
                    begin
                        rec_next.op        = OP_MOVE;
                        rec_next.n_cells   = 3'd1;
                        rec_next.cell_char = in_char_reg;
                        rec_next.cursor    = cursor_reg + STEP_BYTES;
                    end
                endcase
            end
            CMD_SCROLL_UP:
            begin
                rec_next.op = OP_SCROLL_UP;
            end
            CMD_SCROLL_DOWN:
            begin
                rec_next.op = OP_SCROLL_DOWN;
            end
            CMD_LEFT:
            begin
                if (back_blocked)
                begin
                    rec_next.err = 1'b1;
                end
                else
                begin
                    rec_next.op     = OP_MOVE;
                    rec_next.cursor = cursor_reg - STEP_BYTES;
                end
            end
            CMD_RIGHT:
            begin
                rec_next.op     = OP_MOVE;
                rec_next.cursor = cursor_reg + STEP_BYTES;
            end
            default:
            begin
                rec_next.op = OP_STATUS;
            end
        endcase
    end

    // Control state and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rec_valid_reg <= 1'b0;
            cursor_reg    <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (!rec_valid_reg || rec_ready)
            begin
                rec_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                cursor_reg <= rec_next.cursor;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_command_reg <= cmd.command;
            in_char_reg    <= cmd.char_code;
        end
        if (advance)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule

// ===== hdl/tcw_scroll_stage.sv =====
// Scroll stage: display start register, scroll check and per-transaction result plan.
// Depends on tcw_pkg and the assertion macro header.
`include "text_console_writer_assert.svh"

module tcw_scroll_stage
    import tcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rec_valid,
    output logic     rec_ready,
    input  cmd_rec_t rec,
    output logic     plan_valid,
    output plan_t    plan,
    input  logic     plan_done
);

    pos_t  start_reg;
    logic  plan_valid_reg;
    plan_t plan_reg;
    plan_t plan_next;
    pos_t  cursor_row;
    diff_t row_gap;
    logic  need_scroll;
    pos_t  start_up;
    pos_t  start_down;
    logic  load;

    // Free once the sequencer hands over the last result
    assign rec_ready  = !plan_valid_reg || plan_done;
    assign load       = rec_valid && rec_ready;
    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;

    // Scroll check on the moved cursor's row
    assign cursor_row  = row_base(rec.cursor);
    assign row_gap     = diff_t'({1'b0, cursor_row}) - diff_t'({1'b0, start_reg});
    assign need_scroll = (row_gap >= SCROLL_LIMIT);
    assign start_up    = start_reg - ROW_BYTES;
    assign start_down  = start_reg + ROW_BYTES;

    // Build the plan for this transaction
    always_comb
    begin
        plan_next           = '0;
        plan_next.n_cells   = rec.n_cells;
        plan_next.cell_char = rec.cell_char;
        plan_next.cell_base = rec.cell_base;
        plan_next.cursor    = rec.cursor;
        plan_next.start     = start_reg;
        case (rec.op)
            OP_MOVE:
            begin
                plan_next.cursor_en = 1'b1;
                plan_next.start_en  = need_scroll;
                if (need_scroll)
                begin
                    plan_next.start = start_down;
                end
            end
            OP_SCROLL_UP:
            begin
                plan_next.n_cells = '0;
                if (start_reg < ROW_BYTES)
                begin
                    plan_next.status_en = 1'b1;
                end
                else
                begin
                    plan_next.start_en = 1'b1;
                    plan_next.start    = start_up;
                end
            end
            OP_SCROLL_DOWN:
            begin
                plan_next.n_cells  = '0;
                plan_next.start_en = 1'b1;
                plan_next.start    = start_down;
            end
            default:
            begin
                plan_next.n_cells   = '0;
                plan_next.status_en = 1'b1;
                plan_next.err       = rec.err;
            end
        endcase
        if (plan_next.status_en)
        begin
            plan_next.count = 4'd1;
        end
        else
        begin
            plan_next.count = 4'(plan_next.n_cells)
                            + (plan_next.cursor_en ? 4'd2 : 4'd0)
                            + (plan_next.start_en ? 4'd2 : 4'd0);
        end
    end

    // Control state and start offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            start_reg      <= '0;
        end
        else
        begin
            if (rec_ready)
            begin
                plan_valid_reg <= rec_valid;
            end
            if (load)
            begin
                start_reg <= plan_next.start;
            end
        end
    end

    // Plan payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan_next;
        end
    end

    `TCW_CHECK(status_alone, plan_valid_reg |-> !(plan_reg.status_en && (plan_reg.cursor_en || plan_reg.start_en || plan_reg.n_cells != 3'd0)), "status result mixed with other results")

endmodule

// ===== hdl/tcw_result_seq.sv =====
// Result sequencer: walks the held plan and presents each of its results in turn.
// Depends on tcw_pkg, tcw_res_if and the assertion macro header.
`include "text_console_writer_assert.svh"

module tcw_result_seq
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       plan_valid,
    input  plan_t      plan,
    input  logic [7:0] attribute,
    output logic       plan_done,
    tcw_res_if.source  res
);

    logic [2:0] idx_reg;
    logic [2:0] crt_idx;
    logic [1:0] crt_sel;
    pos_t       crt_src;
    pos_t       cell_pos;
    logic       is_cell;
    logic       is_last;
    logic       fire;

    assign fire      = res.valid && res.ready;
    assign is_last   = ((4'(idx_reg) + 4'd1) == plan.count);
    assign plan_done = fire && is_last;

    // Locate the current result inside the plan
    assign is_cell  = (idx_reg < plan.n_cells);
    assign crt_idx  = idx_reg - plan.n_cells;
    assign crt_sel  = plan.cursor_en ? crt_idx[1:0] : (crt_idx[1:0] + CRT_START_HI);
    assign crt_src  = (crt_sel == CRT_CURSOR_HI || crt_sel == CRT_CURSOR_LO)
                    ? plan.cursor : plan.start;
    assign cell_pos = plan.cell_base + (pos_t'(idx_reg) << 1);

    // Drive the result fields
    always_comb
    begin
        res.valid          = plan_valid;
        res.kind           = KIND_STATUS;
        res.cell_offset    = '0;
        res.cell_char      = '0;
        res.cell_attribute = '0;
        res.crt_register   = '0;
        res.crt_value      = '0;
        res.error          = 1'b0;
        res.last           = is_last;
        if (plan.status_en)
        begin
            res.error = plan.err;
        end
        else if (is_cell)
        begin
            res.kind           = KIND_CELL;
            res.cell_offset    = 16'(cell_pos);
            res.cell_char      = plan.cell_char;
            res.cell_attribute = attribute;
        end
        else
        begin
            res.kind         = KIND_CRT;
            res.crt_register = crt_sel;
            res.crt_value    = crt_byte(crt_src,
                                        crt_sel == CRT_CURSOR_HI || crt_sel == CRT_START_HI);
        end
    end

    // Advance through the plan, restart after the last result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (fire)
        begin
            idx_reg <= is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    `TCW_CHECK(count_in_range, plan_valid |-> (plan.count != 4'd0 && plan.count <= 4'd8), "result count out of range")
    `TCW_CHECK(index_below_count, plan_valid |-> (4'(idx_reg) < plan.count), "result index past plan end")
    `TCW_CHECK_NEXT(index_steps, fire && !is_last, (idx_reg == 3'($past(idx_reg) + 3'd1)), "result index did not advance")

endmodule

// ===== hdl/text_console_writer.sv =====
// Top level of the text console writer: attribute register and the three stages.
// Depends on tcw_pkg, tcw_cmd_if, tcw_res_if, tcw_cmd_stage, tcw_scroll_stage, tcw_result_seq.
//
//  channel    | direction | handshake          | payload
//  -----------+-----------+--------------------+------------------------------------------
//  cmd        | in        | valid / ready      | command, char_code
//  res        | out       | valid / ready      | kind, cell_offset, cell_char, cell_attribute,
//             |           |                    | crt_register, crt_value, error, last
//  attribute  | in        | attribute_we       | attribute_wdata (8 bits)
//
// A command passes an input register, a decode stage and a plan register before its
// first result is valid. Each command then holds the result port until all of its 1 to 8
// results (a tab with scroll is the longest) are taken, one at a time through the
// single-result output port. Later commands are accepted and decoded meanwhile.
// Reset clears cursor and start offsets to zero and the attribute to 7; back-pressure on
// res stalls all stages in place with nothing lost.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tcw_cmd_if.sink    cmd,
    tcw_res_if.source  res,
    input  logic       attribute_we,
    input  logic [7:0] attribute_wdata
);

    logic [7:0] attribute_reg;
    logic       rec_valid;
    logic       rec_ready;
    cmd_rec_t   rec;
    logic       plan_valid;
    plan_t      plan;
    logic       plan_done;

    // Hold the colour attribute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_reg <= ATTR_RESET;
        end
        else if (attribute_we)
        begin
            attribute_reg <= attribute_wdata;
        end
    end

    tcw_cmd_stage u_cmd_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    tcw_scroll_stage u_scroll_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec        (rec),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_done  (plan_done)
    );

    tcw_result_seq u_result_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan       (plan),
        .attribute  (attribute_reg),
        .plan_done  (plan_done),
        .res        (res)
    );

endmodule
